// ===== src/ssel_pkg.sv =====
// Shared types and constants for the scanline sprite selector.
// No dependencies; imported by the interfaces, the top module and the bench.
`timescale 1ns / 1ps

package ssel_pkg;

  localparam int MEM_AW           = 6;
  localparam int MEM_ENTRIES      = 1 << MEM_AW;
  localparam int BYTE_LANES       = 4;
  localparam int SPRITE_COUNT_DEF = 64;
  localparam int SLOTS_DEF        = 8;
  localparam int ROWS_DEF         = 8;

  localparam logic [7:0] EMPTY_BYTE = 8'hFF;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  localparam logic [1:0] LANE_Y    = 2'd0;
  localparam logic [1:0] LANE_TILE = 2'd1;
  localparam logic [1:0] LANE_ATTR = 2'd2;
  localparam logic [1:0] LANE_X    = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } ssel_state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] oam_addr;
    logic [7:0] oam_data;
    logic [7:0] scan_line;
  } in_word_t;

  typedef struct packed {
    logic [2:0] slot_index;
    logic       slot_valid;
    logic [7:0] sprite_y;
    logic [7:0] tile_number;
    logic [7:0] attr_byte;
    logic [7:0] sprite_x;
    logic       first_sprite_hit;
    logic       last_slot;
  } out_word_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] tile;
    logic [7:0] attr;
    logic [7:0] x;
  } hit_t;

endpackage

// ===== src/ssel_if.sv =====
// Valid/ready stream interfaces for request and slot words.
// Depends on ssel_pkg for the word types.
`timescale 1ns / 1ps

interface ssel_in_if import ssel_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface ssel_out_if import ssel_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// ===== src/ssel_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module ssel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/scanline_sprite_selector_top.sv =====
// Scanline sprite selector top level: attribute memory, scan and slot output.
// Depends on ssel_pkg, ssel_if and ssel_ram.
//
//   channel   | dir | word       | accepted when
//   in_chan   | in  | in_word_t  | valid && ready
//   out_chan  | out | out_word_t | valid && ready
//
// After reset the attribute memory is cleared, all 64 entries in turn; no word is taken then.
// Write words can be taken back to back. An evaluate word scans one entry per cycle through
// the registered memory read, stopping early once the list fills, then sends
// SLOTS_PER_LINE slot words.
// A stalled out_chan holds the slot register and pauses the slot sequence.
`timescale 1ns / 1ps

module scanline_sprite_selector_top import ssel_pkg::*; #(
  parameter int SPRITE_COUNT   = SPRITE_COUNT_DEF,
  parameter int SLOTS_PER_LINE = SLOTS_DEF,
  parameter int SPRITE_ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ssel_in_if.sink           in_chan,
  ssel_out_if.source        out_chan
);

  localparam int ECW     = $clog2(SPRITE_COUNT + 1);
  localparam int SCW     = $clog2(SLOTS_PER_LINE + 1);
  localparam int LIST_AW = (SLOTS_PER_LINE > 1) ? $clog2(SLOTS_PER_LINE) : 1;

  ssel_state_t      state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ECW-1:0]   issue_cnt_r, issue_cnt_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             rd_zero_r, rd_zero_nxt;
  logic [SCW-1:0]   hits_r, hits_nxt;
  logic             first_r, first_nxt;
  logic [7:0]       line_r, line_nxt;
  logic [SCW-1:0]   slot_r, slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;
  hit_t             hit_list_r [SLOTS_PER_LINE];

  logic [BYTE_LANES-1:0] ram_we;
  logic [MEM_AW-1:0]     ram_waddr;
  logic [7:0]            ram_wdata;
  logic [MEM_AW-1:0]     ram_raddr;
  logic [7:0]            ram_rdata [BYTE_LANES];

  logic       issue;
  logic       hit;
  logic       hit_we;
  logic [7:0] top;
  logic [8:0] bottom;
  hit_t       hit_data;
  hit_t       slot_data;
  logic       slot_used;

  for (genvar g = 0; g < BYTE_LANES; g++) begin : g_lane
    ssel_ram #(
      .WIDTH (8),
      .DEPTH (MEM_ENTRIES)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata[g])
    );
  end

  assign ram_raddr = MEM_AW'(issue_cnt_r);

  assign top      = ram_rdata[LANE_Y] + 8'd1;
  assign bottom   = {1'b0, top} + 9'(SPRITE_ROWS);
  assign hit      = (line_r >= top) && ({1'b0, line_r} < bottom);
  assign hit_data = '{y: top, tile: ram_rdata[LANE_TILE], attr: ram_rdata[LANE_ATTR],
                      x: ram_rdata[LANE_X]};

  assign slot_used = slot_r < hits_r;
  assign slot_data = hit_list_r[slot_r[LIST_AW-1:0]];

  assign out_chan.valid = out_valid_r;
  assign out_chan.word  = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    issue_cnt_nxt = issue_cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_zero_nxt   = rd_zero_r;
    hits_nxt      = hits_r;
    first_nxt     = first_r;
    line_nxt      = line_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_word_nxt  = out_word_r;
    ram_we        = '0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    in_chan.ready = 1'b0;
    issue         = 1'b0;
    hit_we        = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = '1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          if (in_chan.word.req_type == REQ_WRITE) begin
            ram_we[in_chan.word.oam_addr[1:0]] = 1'b1;
            ram_waddr = in_chan.word.oam_addr[7:2];
            ram_wdata = in_chan.word.oam_data;
          end else begin
            line_nxt      = in_chan.word.scan_line;
            issue_cnt_nxt = '0;
            hits_nxt      = '0;
            first_nxt     = 1'b0;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        issue = (issue_cnt_r != ECW'(SPRITE_COUNT)) &&
                (hits_r != SCW'(SLOTS_PER_LINE));
        rd_pend_nxt = issue;
        rd_zero_nxt = (issue_cnt_r == '0);
        if (issue) begin
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end
        if (rd_pend_r && hit && (hits_r != SCW'(SLOTS_PER_LINE))) begin
          hit_we   = 1'b1;
          hits_nxt = hits_r + 1'b1;
          if (rd_zero_r) begin
            first_nxt = 1'b1;
          end
        end
        if (!issue && !rd_pend_r) begin
          slot_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt                 = 1'b1;
          out_word_nxt.slot_index       = 3'(slot_r);
          out_word_nxt.slot_valid       = slot_used;
          out_word_nxt.sprite_y         = slot_used ? slot_data.y    : EMPTY_BYTE;
          out_word_nxt.tile_number      = slot_used ? slot_data.tile : EMPTY_BYTE;
          out_word_nxt.attr_byte        = slot_used ? slot_data.attr : EMPTY_BYTE;
          out_word_nxt.sprite_x         = slot_used ? slot_data.x    : EMPTY_BYTE;
          out_word_nxt.first_sprite_hit = first_r;
          out_word_nxt.last_slot        = (slot_r == SCW'(SLOTS_PER_LINE - 1));
          slot_nxt                      = slot_r + 1'b1;
          if (slot_r == SCW'(SLOTS_PER_LINE - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      issue_cnt_r <= '0;
      rd_pend_r   <= 1'b0;
      rd_zero_r   <= 1'b0;
      hits_r      <= '0;
      first_r     <= 1'b0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_zero_r   <= rd_zero_nxt;
      hits_r      <= hits_nxt;
      first_r     <= first_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r     <= line_nxt;
    out_word_r <= out_word_nxt;
    if (hit_we) begin
      hit_list_r[hits_r[LIST_AW-1:0]] <= hit_data;
    end
  end

endmodule

// ===== tb/sv/tb_scanline_sprite_selector_top.sv =====
// Self-checking bench for scanline_sprite_selector_top: writes sprite bytes, evaluates lines
// and compares every slot word against an in-bench sprite list predictor.
// Depends on ssel_pkg, ssel_if and the block's RTL.
`timescale 1ns / 1ps

module tb_scanline_sprite_selector_top;
  import ssel_pkg::*;

  localparam int SPRITES   = SPRITE_COUNT_DEF;
  localparam int SLOTS     = SLOTS_DEF;
  localparam int ROWS      = ROWS_DEF;
  localparam int RAND_REQS = 150;
  localparam int LIMIT     = 200000;

  class sprite_slot_board;
    logic [7:0] sprite_mem [256];
    out_word_t  exp_slots [$];
    int         errors;

    function new();
      foreach (sprite_mem[i]) sprite_mem[i] = 8'h00;
      errors = 0;
    endfunction

    function int pending();
      return exp_slots.size();
    endfunction

    // Writes update the memory copy; evaluations queue one word per slot.
    function void note_request(in_word_t w);
      logic [7:0] base;
      logic [7:0] top;
      hit_t       found [SLOTS];
      int         hits;
      bit         first;
      out_word_t  slot;
      if (w.req_type == REQ_WRITE) begin
        sprite_mem[w.oam_addr] = w.oam_data;
        return;
      end
      hits  = 0;
      first = 1'b0;
      for (int e = 0; e < SPRITES && hits < SLOTS; e++) begin
        base = 8'(e * BYTE_LANES);
        top  = sprite_mem[base + LANE_Y] + 8'd1;
        // upper bound does not wrap
        if (w.scan_line >= top && int'(w.scan_line) < int'(top) + ROWS) begin
          found[hits].y    = top;
          found[hits].tile = sprite_mem[base + LANE_TILE];
          found[hits].attr = sprite_mem[base + LANE_ATTR];
          found[hits].x    = sprite_mem[base + LANE_X];
          if (e == 0) first = 1'b1;
          hits++;
        end
      end
      for (int s = 0; s < SLOTS; s++) begin
        slot.slot_index       = 3'(s);
        slot.slot_valid       = (s < hits);
        slot.sprite_y         = (s < hits) ? found[s].y    : EMPTY_BYTE;
        slot.tile_number      = (s < hits) ? found[s].tile : EMPTY_BYTE;
        slot.attr_byte        = (s < hits) ? found[s].attr : EMPTY_BYTE;
        slot.sprite_x         = (s < hits) ? found[s].x    : EMPTY_BYTE;
        slot.first_sprite_hit = first;
        slot.last_slot        = (s == SLOTS - 1);
        exp_slots.push_back(slot);
      end
    endfunction

    function void cmp_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_slot(out_word_t got);
      out_word_t exp_w;
      if (exp_slots.size() == 0) begin
        $error("slot word with nothing pending: %h", got);
        errors++;
        return;
      end
      exp_w = exp_slots.pop_front();
      cmp_field("slot_index", exp_w.slot_index, got.slot_index);
      cmp_field("slot_valid", exp_w.slot_valid, got.slot_valid);
      cmp_field("sprite_y", exp_w.sprite_y, got.sprite_y);
      cmp_field("tile_number", exp_w.tile_number, got.tile_number);
      cmp_field("attr_byte", exp_w.attr_byte, got.attr_byte);
      cmp_field("sprite_x", exp_w.sprite_x, got.sprite_x);
      cmp_field("first_sprite_hit", exp_w.first_sprite_hit, got.first_sprite_hit);
      cmp_field("last_slot", exp_w.last_slot, got.last_slot);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_gaps;
  int   req_count;

  ssel_in_if  in_chan ();
  ssel_out_if out_chan ();

  sprite_slot_board board;

  scanline_sprite_selector_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    board = new();
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) board.note_request(in_chan.word);
    if (rst_n && out_chan.valid && out_chan.ready) board.check_slot(out_chan.word);
  end

  // result side back-pressure
  initial begin : slot_sink
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.word  <= w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    req_count++;
  endtask

  task automatic send_write(logic [7:0] addr, logic [7:0] data);
    in_word_t w;
    w.req_type  = REQ_WRITE;
    w.oam_addr  = addr;
    w.oam_data  = data;
    w.scan_line = 8'($urandom);
    send_word(w);
  endtask

  task automatic send_eval(logic [7:0] line);
    in_word_t w;
    w.req_type  = REQ_EVAL;
    w.oam_addr  = 8'($urandom);
    w.oam_data  = 8'($urandom);
    w.scan_line = line;
    send_word(w);
  endtask

  // Place a few sprites around one line, some just outside it, then evaluate it, and sometimes a nearby line too.
  task automatic run_scene();
    logic [7:0] line;
    logic [7:0] entry_base;
    int         count;
    line  = 8'($urandom);
    count = $urandom_range(1, 10);
    for (int i = 0; i < count; i++) begin
      entry_base = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3) * 4)
                                               : 8'($urandom_range(0, SPRITES - 1) * 4);
      send_write(entry_base + LANE_Y, line - 8'd1 - 8'($urandom_range(0, ROWS + 1)));
      if ($urandom_range(0, 1)) send_write(entry_base + LANE_TILE, 8'($urandom));
      if ($urandom_range(0, 1)) send_write(entry_base + LANE_ATTR, 8'($urandom));
      if ($urandom_range(0, 1)) send_write(entry_base + LANE_X, 8'($urandom));
    end
    send_eval(line);
    if ($urandom_range(0, 2) == 0) send_eval(line + 8'($urandom_range(0, ROWS)));
  endtask

  initial begin : stimulus
    int start_count;
    int pick;
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.word  <= '0;
    no_gaps       = 1'b0;
    req_count     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // cleared memory: every sprite sits at top 1
    send_eval(8'd0);
    send_eval(8'd1);
    send_eval(8'd8);
    send_eval(8'd9);
    // y of 0xFF wraps to top 0
    send_write(8'd0, 8'hFF);
    send_write(8'd1, 8'hAB);
    send_write(8'd2, 8'h5C);
    send_write(8'd3, 8'h00);
    send_write(8'd255, 8'hFF);
    send_eval(8'd0);
    send_eval(8'd7);
    // top 0xFF covers only line 255
    send_write(8'd4, 8'hFE);
    send_eval(8'd255);
    send_eval(8'd0);
    // move sprite 0 away so the list fills without it
    send_write(8'd0, 8'h10);
    send_eval(8'h11);
    send_eval(8'd1);
    send_write(8'd252, 8'hF7);
    send_eval(8'hFF);
    send_eval(8'hF8);

    start_count = req_count;
    while (req_count - start_count < RAND_REQS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 9);
      if (pick < 7) run_scene();
      else if (pick < 9) send_write(8'($urandom), 8'($urandom));
      else send_eval(8'($urandom));
    end
    in_chan.valid <= 1'b0;
    no_gaps = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== scanline_sprite_selector_top.f =====
src/ssel_pkg.sv
src/ssel_if.sv
src/ssel_ram.sv
src/scanline_sprite_selector_top.sv
tb/sv/tb_scanline_sprite_selector_top.sv
